### sv/stx_etx_lrc_frame_receiver_core_assert.svh
// assertion macros for the stx/etx lrc frame receiver
`ifndef STX_ETX_LRC_FRAME_RECEIVER_CORE_ASSERT_SVH
`define STX_ETX_LRC_FRAME_RECEIVER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SELRX_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SELRX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/selrx_pkg.sv
// types and constants shared by the stx/etx lrc frame receiver
`default_nettype none

package selrx_pkg;

  localparam logic [7:0] CHAR_STX = 8'h02;
  localparam logic [7:0] CHAR_ETX = 8'h03;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_BUSY     = 3'd1,
    ST_OK       = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_OVERRUN  = 3'd4,
    ST_MISMATCH = 3'd5,
    ST_ABORT    = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HUNT = 4'b0010,
    PH_BODY = 4'b0100,
    PH_LRC  = 4'b1000
  } phase_e;

  typedef struct packed {
    cmd_e        command;
    logic        abort_pressed;
    logic [7:0]  rx_byte;
  } item_t;

  // first member sits in the top bits, so the packed order matches tdata
  typedef struct packed {
    logic [15:0] error_tally;
    logic [15:0] ok_tally;
    logic        send_nak;
    status_e     status;
    logic        byte_valid;
    logic [7:0]  byte_index;
    logic [7:0]  frame_byte;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

`default_nettype wire

### sv/selrx_engine.sv
// frame state, lrc, timeout and tallies, updated once per item
`default_nettype none

module selrx_engine
  import selrx_pkg::*;
#(
  parameter int unsigned FRAME_SIZE = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] cfg_wdata_i,
  input  wire logic       fire_i,
  input  wire item_t      item_i,
  output result_t         result_o
);

  localparam int unsigned OfsW = $clog2(FRAME_SIZE);
  localparam logic [OfsW-1:0] OfsLast = OfsW'(FRAME_SIZE - 1);

  logic [3:0]      timeout_code_q;
  phase_e          phase_q, phase_d;
  logic [7:0]      lrc_q, lrc_d;
  logic [OfsW-1:0] ofs_q, ofs_d;
  logic [4:0]      tick_q, tick_d;
  logic [15:0]     good_q, good_d;
  logic [15:0]     bad_q, bad_d;
  logic            done;
  result_t         res;

  // timeout setting register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_code_q <= '0;
    end else if (cfg_we_i) begin
      timeout_code_q <= cfg_wdata_i;
    end
  end

  // next state and result for the item in the input register
  always_comb begin
    phase_d = phase_q;
    lrc_d   = lrc_q;
    ofs_d   = ofs_q;
    tick_d  = tick_q;
    good_d  = good_q;
    bad_d   = bad_q;
    done    = 1'b0;
    res     = '0;
    res.status = ST_BUSY;

    unique case (item_i.command)
      CMD_START: begin
        phase_d = PH_HUNT;
        lrc_d   = '0;
        ofs_d   = '0;
        tick_d  = '0;
      end
      CMD_CLEAR: begin
        good_d = '0;
        bad_d  = '0;
      end
      CMD_BYTE: begin
        if (phase_q != PH_IDLE) begin
          tick_d = '0;
          unique case (phase_q)
            PH_HUNT: begin
              if (item_i.rx_byte == CHAR_STX) begin
                res.frame_byte = item_i.rx_byte;
                res.byte_valid = 1'b1;
                lrc_d   = '0;
                ofs_d   = OfsW'(1);
                phase_d = PH_BODY;
              end
            end
            PH_BODY: begin
              res.frame_byte = item_i.rx_byte;
              res.byte_index = 8'(ofs_q);
              res.byte_valid = 1'b1;
              lrc_d = lrc_q ^ item_i.rx_byte;
              if (item_i.rx_byte == CHAR_ETX) begin
                phase_d = PH_LRC;
              end else if (ofs_q == OfsLast) begin
                // body filled the frame without etx
                res.status = ST_OVERRUN;
                if (bad_q != '1) bad_d = bad_q + 16'd1;
                done = 1'b1;
              end else begin
                ofs_d = ofs_q + OfsW'(1);
              end
            end
            PH_LRC: begin
              if (item_i.rx_byte == lrc_q) begin
                res.status = ST_OK;
                if (good_q != '1) good_d = good_q + 16'd1;
              end else begin
                res.status   = ST_MISMATCH;
                res.send_nak = 1'b1;
                if (bad_q != '1) bad_d = bad_q + 16'd1;
              end
              done = 1'b1;
            end
            default: ;
          endcase
        end
      end
      CMD_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (item_i.abort_pressed) begin
            res.status = ST_ABORT;
            done = 1'b1;
          end else if (tick_q >= {timeout_code_q, 1'b1}) begin
            // limit is (code+1)*2 ticks
            res.status = ST_TIMEOUT;
            if (bad_q != '1) bad_d = bad_q + 16'd1;
            done = 1'b1;
          end else begin
            tick_d = tick_q + 5'd1;
          end
        end
      end
      default: ;
    endcase

    if (done) begin
      phase_d = PH_IDLE;
      tick_d  = '0;
    end else begin
      res.status = (phase_d == PH_IDLE) ? ST_IDLE : ST_BUSY;
    end

    res.ok_tally    = good_d;
    res.error_tally = bad_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      lrc_q   <= '0;
      ofs_q   <= '0;
      tick_q  <= '0;
      good_q  <= '0;
      bad_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      lrc_q   <= lrc_d;
      ofs_q   <= ofs_d;
      tick_q  <= tick_d;
      good_q  <= good_d;
      bad_q   <= bad_d;
    end
  end

  assign result_o = res;

endmodule

`default_nettype wire

### sv/selrx_out_reg.sv
// result register with stream handshake toward the consumer
`default_nettype none

module selrx_out_reg
  import selrx_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t data_i,
  output logic         free_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      data_o
);

  logic    valid_q;
  result_t data_q;

  // register can take a result when empty or being drained this cycle
  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### sv/stx_etx_lrc_frame_receiver_core.sv
// top level of the stx/etx lrc frame receiver
//
// Receives one STX/ETX framed response per start command: bytes before STX are
// dropped, STX and the body through ETX are echoed with their offset, the byte
// after ETX is checked against the XOR of the body through ETX, and ticks without
// bytes end the frame by timeout or abort. One item is accepted every clock cycle
// while the output is not stalled; each item goes through an input register and
// a result register, and its result is registered as the item moves from the
// input register into the result register, which is also when the frame state
// updates. Back-pressure from the output stalls both registers.
`default_nettype none

module stx_etx_lrc_frame_receiver_core
  import selrx_pkg::*;
#(
  parameter int unsigned FRAME_SIZE = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // timeout setting
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_wdata_i,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [7:0] rx_byte, [8] abort_pressed, rest zero
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] command
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata   // [7:0] frame_byte, [15:8] byte_index,
                                          // [16] byte_valid, [19:17] status,
                                          // [20] send_nak, [36:21] ok_tally,
                                          // [52:37] error_tally, rest zero
);

  `include "stx_etx_lrc_frame_receiver_core_assert.svh"

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_free;
  logic    fire;
  result_t eng_res;
  result_t out_res;

  // item moves into the result stage when that stage has room
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.command       <= cmd_e'(s_axis_tuser);
      in_item_q.abort_pressed <= s_axis_tdata[8];
      in_item_q.rx_byte       <= s_axis_tdata[7:0];
    end
  end

  selrx_engine #(
    .FRAME_SIZE (FRAME_SIZE)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (in_item_q),
    .result_o    (eng_res)
  );

  selrx_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_valid_q),
    .data_i  (eng_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_res)
  );

  assign m_axis_tdata = {(56 - ResultW)'(0), out_res};

  // checks
  `SELRX_ASSERT_NOW(a_nak_only_on_mismatch, clk_i, rst_ni,
    m_axis_tvalid && out_res.send_nak, out_res.status == ST_MISMATCH, "nak without mismatch")
  `SELRX_ASSERT_NOW(a_echo_clean, clk_i, rst_ni,
    m_axis_tvalid && !out_res.byte_valid,
    out_res.frame_byte == 8'd0 && out_res.byte_index == 8'd0, "stale echo fields")
  `SELRX_ASSERT_NEXT(a_stall_keeps_input, clk_i, rst_ni,
    in_valid_q && m_axis_tvalid && !m_axis_tready, in_valid_q, "input stage lost an item")

endmodule

`default_nettype wire
